### rtl/sfr_pkg.sv
// Shared constants, register codes and item types of the stream find/replace block.
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int BYTE_W      = 8;
    localparam int WIN_W       = MAX_PATTERN * BYTE_W;
    localparam int REP_W       = MAX_REPLACE * BYTE_W;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_REPLACE_BYTES  = 2'd2,
        REG_REPLACE_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_line;
    } text_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              line_end;
        logic              run_last;
    } result_item_t;

    typedef struct packed {
        cfg_reg_t                index;
        logic [CFG_DATA_W-1:0]   wdata;
    } cfg_item_t;

endpackage

### rtl/sfr_ifs.sv
// Valid/ready channel interfaces for text input, result output and configuration.
interface sfr_text_if;
    logic                 valid;
    logic                 ready;
    sfr_pkg::text_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfr_result_if;
    logic                   valid;
    logic                   ready;
    sfr_pkg::result_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfr_cfg_if;
    logic                valid;
    logic                ready;
    sfr_pkg::cfg_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/stream_find_replace.sv
// Top level: streaming find-and-replace over the bytes of a text line.
//
// Channels: text carries one byte and an end-of-line flag per item; result
// carries one output byte, or a bare line-end marker, per item, with run_last
// set on the last item caused by a given input byte; cfg writes the pattern,
// pattern length, replacement and replacement length registers (always ready).
// Each accepted byte is resolved in its acceptance cycle: the match window is
// updated and the items it causes are loaded into a burst register, which
// shows its first item on the next cycle.
// Throughput: one input byte per cycle while each byte causes at most one
// item. A byte causing N items holds the text channel until its last item
// is taken, since the burst register drains one item per cycle; the next
// byte is accepted in that cycle. Bytes that only fill the window cause no items.
// When the receiver stalls, the current item holds and text input waits.
// Reset clears all registers: pattern length zero, so bytes pass unchanged,
// and the window and burst register are empty. Writing the pattern length
// empties the window.
module stream_find_replace (
    input logic          clk,
    input logic          rst_n,
    sfr_text_if.sink     text,
    sfr_result_if.source result,
    sfr_cfg_if.sink      cfg
);
    import sfr_pkg::*;

    // configuration registers
    logic [WIN_W-1:0]  pat_bytes_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    logic [REP_W-1:0]  rep_bytes_reg;
    logic [LEN_W-1:0]  rep_len_reg;

    // match window and burst register
    logic [WIN_W-1:0]  win_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [WIN_W-1:0]  buf_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic              mark_reg;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [WIN_W-1:0]  win_app;
    logic [LEN_W-1:0]  fill_inc;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic              hit;
    logic [REP_W-1:0]  rep_mask;
    logic [WIN_W-1:0]  head_vec;
    logic [LEN_W-1:0]  head_cnt;
    logic [WIN_W-1:0]  rem_vec;
    logic [LEN_W-1:0]  rem_fill;
    logic [WIN_W-1:0]  burst_next;
    logic [LEN_W-1:0]  cnt_next;
    logic [LEN_W-1:0]  fill_next;
    logic              run_last;
    logic              accept;
    logic              pop;
    logic              plen_wr;

    // effective lengths, oversized values clamp to the maximum
    assign plen = (pat_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_reg;
    assign rlen = (rep_len_reg > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE) : rep_len_reg;

    // window with the new byte placed at the fill position, and pattern compare
    assign fill_inc = fill_reg + LEN_W'(1);
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_app[i*BYTE_W +: BYTE_W] = (fill_reg == LEN_W'(i)) ? text.data.in_byte
                                                                  : win_reg[i*BYTE_W +: BYTE_W];
            byte_ok[i] = (LEN_W'(i) >= plen) ||
                         (win_app[i*BYTE_W +: BYTE_W] == pat_bytes_reg[i*BYTE_W +: BYTE_W]);
        end
        for (int i = 0; i < MAX_REPLACE; i++)
        begin
            rep_mask[i*BYTE_W +: BYTE_W] = (LEN_W'(i) < rlen) ? {BYTE_W{1'b1}}
                                                              : {BYTE_W{1'b0}};
        end
    end
    assign hit = (&byte_ok) && (fill_inc == plen);

    // items caused by this byte: head (pass, replacement or oldest byte),
    // then the flushed window and a marker at end of line
    always_comb
    begin
        head_vec = '0;
        head_cnt = '0;
        rem_vec  = win_app;
        rem_fill = fill_inc;
        if (plen == '0)
        begin
            head_vec = {{(WIN_W-BYTE_W){1'b0}}, text.data.in_byte};
            head_cnt = LEN_W'(1);
            rem_fill = '0;
        end
        else if (fill_inc == plen)
        begin
            if (hit)
            begin
                head_vec = rep_bytes_reg & rep_mask;
                head_cnt = rlen;
                rem_fill = '0;
            end
            else
            begin
                head_vec = {{(WIN_W-BYTE_W){1'b0}}, win_app[BYTE_W-1:0]};
                head_cnt = LEN_W'(1);
                rem_vec  = win_app >> BYTE_W;
                rem_fill = plen - LEN_W'(1);
            end
        end

        if (text.data.end_of_line)
        begin
            burst_next = head_vec | (rem_vec << {head_cnt, 3'b000});
            cnt_next   = head_cnt + rem_fill;
            fill_next  = '0;
        end
        else
        begin
            burst_next = head_vec;
            cnt_next   = head_cnt;
            fill_next  = rem_fill;
        end
    end

    // result item from the burst register
    always_comb
    begin
        result.valid = (cnt_reg != '0) || mark_reg;
        if (cnt_reg != '0)
        begin
            run_last                 = (cnt_reg == LEN_W'(1)) && !mark_reg;
            result.data.out_byte     = buf_reg[BYTE_W-1:0];
            result.data.byte_valid   = 1'b1;
            result.data.line_end     = 1'b0;
        end
        else
        begin
            run_last                 = 1'b1;
            result.data.out_byte     = '0;
            result.data.byte_valid   = 1'b0;
            result.data.line_end     = 1'b1;
        end
        result.data.run_last = run_last;
    end

    assign pop        = result.valid && result.ready;
    assign text.ready = !result.valid || (result.ready && run_last);
    assign accept     = text.valid && text.ready;
    assign cfg.ready  = 1'b1;
    assign plen_wr    = cfg.valid && (cfg.data.index == REG_PATTERN_LENGTH);

    // control state: configuration, window fill, burst count and marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            mark_reg      <= 1'b0;
        end
        else
        begin
            // a pattern length write empties the window
            if (plen_wr)
                fill_reg <= '0;
            else if (accept)
                fill_reg <= fill_next;

            if (accept)
            begin
                cnt_reg  <= cnt_next;
                mark_reg <= text.data.end_of_line;
            end
            else if (pop)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - LEN_W'(1);
                else
                    mark_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                case (cfg.data.index)
                    REG_PATTERN_BYTES:  pat_bytes_reg <= cfg.data.wdata[WIN_W-1:0];
                    REG_PATTERN_LENGTH: pat_len_reg   <= cfg.data.wdata[LEN_W-1:0];
                    REG_REPLACE_BYTES:  rep_bytes_reg <= cfg.data.wdata[REP_W-1:0];
                    REG_REPLACE_LENGTH: rep_len_reg   <= cfg.data.wdata[LEN_W-1:0];
                    default:            pat_bytes_reg <= pat_bytes_reg;
                endcase
            end
        end
    end

    // payload: window bytes and burst bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            buf_reg <= '0;
        end
        else if (accept)
        begin
            win_reg <= rem_vec;
            buf_reg <= burst_next;
        end
        else if (pop)
        begin
            buf_reg <= buf_reg >> BYTE_W;
        end
    end

endmodule

### rtl/sfr_checker.sv
// Port-level checks of the stream find/replace top level, bound to it.
module sfr_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  text_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input sfr_pkg::result_item_t res_data
);
    import sfr_pkg::*;

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result item changed");

    // no new byte is taken while a burst has items beyond the one shown
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.run_last) |-> !text_ready)
        else $error("text accepted in the middle of a burst");

    // the line-end marker is bare and closes its burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.line_end) |-> (!res_data.byte_valid && res_data.run_last))
        else $error("malformed line-end marker");

    // every item is either a byte or a marker
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.byte_valid != res_data.line_end))
        else $error("item is neither byte nor marker");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_ready (text.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_data   (result.data)
);

### test/tb_stream_find_replace.sv
// Self-checking testbench for the stream find/replace block: directed and random text lines.
`timescale 1ns / 100ps

module tb_stream_find_replace;

    import sfr_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 460;
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS = 40;

    logic clk = 1'b0;
    logic rst_n;

    sfr_text_if   text_ch ();
    sfr_result_if result_ch ();
    sfr_cfg_if    cfg_ch ();

    stream_find_replace dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Shadow copy of the block: registers and match window
    logic [CFG_DATA_W-1:0] pat_bytes;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] rep_bytes;
    logic [LEN_W-1:0]      rep_len;
    logic [BYTE_W-1:0]     win [MAX_PATTERN];
    int unsigned           win_fill;

    text_item_t   text_backlog [$];
    result_item_t replaced_stream [$];

    int  items_queued = 0;
    int  items_accepted = 0;
    int  lines_queued = 0;
    int  results_checked = 0;
    int  cfg_writes = 0;
    int  settings_used = 0;
    int  errors = 0;
    bit  idling_on = 1'b0;
    int  hold_req = 0;
    int  hold_served;
    int  tx_gap;
    int  rx_gap;
    int  stall_left;
    logic [BYTE_W-1:0] letter_base = 8'h61;
    result_item_t want;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (!idling_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic result_item_t make_item(logic [BYTE_W-1:0] b, logic valid, logic le);
        result_item_t it;
        it.out_byte   = b;
        it.byte_valid = valid;
        it.line_end   = le;
        it.run_last   = 1'b0;
        return it;
    endfunction

    // Advance the shadow window by one text byte; append the items it causes
    task automatic find_replace_step(input text_item_t it);
        result_item_t burst [$];
        int unsigned plen;
        int unsigned rlen;
        bit hit;
        plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
        rlen = (rep_len > MAX_REPLACE) ? MAX_REPLACE : rep_len;
        if (plen == 0)
            burst.push_back(make_item(it.in_byte, 1'b1, 1'b0));
        else
        begin
            if (win_fill >= plen)
                win_fill = 0;
            win[win_fill] = it.in_byte;
            win_fill++;
            if (win_fill == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (win[i] != pat_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                        burst.push_back(make_item(rep_bytes[8*i +: 8], 1'b1, 1'b0));
                    win_fill = 0;
                end
                else
                begin
                    // no match: oldest byte leaves, rest shift down
                    burst.push_back(make_item(win[0], 1'b1, 1'b0));
                    for (int i = 1; i < win_fill; i++)
                        win[i-1] = win[i];
                    win_fill--;
                end
            end
        end
        // end of line flushes the window, then a bare marker
        if (it.end_of_line)
        begin
            for (int i = 0; i < win_fill; i++)
                burst.push_back(make_item(win[i], 1'b1, 1'b0));
            win_fill = 0;
            burst.push_back(make_item('0, 1'b0, 1'b1));
        end
        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[i])
            replaced_stream.push_back(burst[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
        end
    endtask

    // Text driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ch.valid <= 1'b0;
            text_ch.data  <= '0;
            tx_gap        <= 0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                find_replace_step(text_ch.data);
                items_accepted++;
            end
            if (!text_ch.valid || text_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    text_ch.valid <= 1'b0;
                    tx_gap        <= tx_gap - 1;
                end
                else if (text_backlog.size() > 0)
                begin
                    text_ch.data  <= text_backlog.pop_front();
                    text_ch.valid <= 1'b1;
                    tx_gap        <= pick_gap();
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
            hold_served     <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (replaced_stream.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unpredicted result: expected none, got %h/%b/%b/%b",
                                 $time, result_ch.data.out_byte, result_ch.data.byte_valid,
                                 result_ch.data.line_end, result_ch.data.run_last);
                end
                else
                begin
                    want = replaced_stream.pop_front();
                    check_field("out_byte", want.out_byte, result_ch.data.out_byte);
                    check_field("byte_valid", want.byte_valid, result_ch.data.byte_valid);
                    check_field("line_end", want.line_end, result_ch.data.line_end);
                    check_field("run_last", want.run_last, result_ch.data.run_last);
                    results_checked++;
                end
            end
            // long hold-off on request, else random stalls
            if (hold_served != hold_req)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= LONG_HOLD;
                hold_served     <= hold_served + 1;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= stall_left - 1;
            end
            else
            begin
                rx_gap = pick_gap();
                if (rx_gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    stall_left      <= rx_gap - 1;
                end
                else
                    result_ch.ready <= 1'b1;
            end
        end
    end

    // One register write; valid stays high for a following write
    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.data  <= '{index: idx, wdata: val};
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_writes++;
        case (idx)
            REG_PATTERN_BYTES:  pat_bytes = val;
            REG_PATTERN_LENGTH:
            begin
                pat_len  = val[LEN_W-1:0];
                win_fill = 0;
                foreach (win[i])
                    win[i] = '0;
            end
            REG_REPLACE_BYTES:  rep_bytes = val;
            REG_REPLACE_LENGTH: rep_len = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Write the registers selected by mask (bit i = register index i)
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] pb, input logic [CFG_DATA_W-1:0] pl,
                                  input logic [CFG_DATA_W-1:0] rb, input logic [CFG_DATA_W-1:0] rl,
                                  input logic [3:0] mask);
        if (mask[REG_PATTERN_BYTES])
            cfg_write(REG_PATTERN_BYTES, pb);
        if (mask[REG_REPLACE_BYTES])
            cfg_write(REG_REPLACE_BYTES, rb);
        if (mask[REG_REPLACE_LENGTH])
            cfg_write(REG_REPLACE_LENGTH, rl);
        if (mask[REG_PATTERN_LENGTH])
            cfg_write(REG_PATTERN_LENGTH, pl);
        if (mask != 4'h0)
            cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_item(input logic [BYTE_W-1:0] b, input logic eol);
        text_item_t it;
        it.in_byte     = b;
        it.end_of_line = eol;
        text_backlog.push_back(it);
        items_queued++;
        if (eol)
            lines_queued++;
    endtask

    task automatic queue_text(input string s, input bit eol_last);
        for (int i = 0; i < s.len(); i++)
            queue_item(s[i], eol_last && (i == s.len() - 1));
    endtask

    // Block is idle: every item taken, every result seen, pipeline drained
    task automatic wait_idle();
        while (items_accepted != items_queued || replaced_stream.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random settings for one phase; pattern usually from a small alphabet
    task automatic random_settings(input bit all_regs);
        logic [CFG_DATA_W-1:0] pb;
        logic [CFG_DATA_W-1:0] rb;
        logic [CFG_DATA_W-1:0] pl;
        logic [CFG_DATA_W-1:0] rl;
        logic [3:0] mask;
        int r;
        int len;
        letter_base = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
            pb = {$urandom, $urandom};
        else
            for (int i = 0; i < MAX_PATTERN; i++)
                pb[8*i +: 8] = letter_base + 8'($urandom_range(0, 2));
        rb = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 8)
            len = 0;
        else if (r < 70)
            len = $urandom_range(1, 4);
        else if (r < 85)
            len = $urandom_range(5, 8);
        else if (r < 93)
            len = MAX_PATTERN;
        else
            len = $urandom_range(9, 15);
        pl = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : '0;
        pl[LEN_W-1:0] = LEN_W'(len);
        r = $urandom_range(0, 99);
        if (r < 15)
            len = 0;
        else if (r < 80)
            len = $urandom_range(1, 4);
        else if (r < 92)
            len = $urandom_range(5, 8);
        else
            len = $urandom_range(9, 15);
        rl = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : '0;
        rl[LEN_W-1:0] = LEN_W'(len);
        mask = all_regs ? 4'hF : 4'($urandom_range(0, 15));
        apply_settings(pb, pl, rb, rl, mask);
    endtask

    // Lines built from copies and prefixes of the pattern, with some noise
    task automatic queue_phase(input int count, input bit leave_open);
        logic [BYTE_W-1:0] text_line [$];
        int start;
        int plen;
        int n;
        int r;
        start = items_queued;
        while (items_queued - start < count)
        begin
            text_line.delete();
            plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 10)) text_line.push_back(8'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 5))
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        n = (plen == 0) ? 1 : plen;
                    else if (r < 7)
                        n = (plen < 2) ? 1 : $urandom_range(1, plen - 1);
                    else
                        n = 0;
                    for (int i = 0; i < n; i++)
                        text_line.push_back(pat_bytes[8*i +: 8]);
                    if (r == 7 || r == 8)
                        text_line.push_back(letter_base + 8'($urandom_range(0, 2)));
                    else if (r == 9)
                        text_line.push_back(8'($urandom_range(0, 255)));
                end
            foreach (text_line[i])
                queue_item(text_line[i], (i == text_line.size() - 1) &&
                           !(leave_open && items_queued - start + 1 >= count));
        end
    endtask

    // Overall run limit
    initial
    begin
        #10_000_000;
        $display("tb_stream_find_replace failed");
        $finish;
    end

    initial
    begin
        int phase_no;
        int count;
        bit hold_phase;
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        pat_bytes        = '0;
        pat_len          = '0;
        rep_bytes        = '0;
        rep_len          = '0;
        win_fill         = 0;
        foreach (win[i])
            win[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through after reset, byte extremes
        idling_on = 1'b1;
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b1);
        queue_item(8'h5A, 1'b0);
        wait_idle();

        // "ab" -> "XYZ": leftmost match, repeated match, match mid-line, open window
        apply_settings(64'h6261, 64'd2, 64'h5A5958, 64'd3, 4'hF);
        queue_text("aabab", 1'b1);
        queue_text("ab", 1'b0);
        queue_text("xa", 1'b0);
        wait_idle();

        // pattern and replacement changed mid-line, window kept
        apply_settings(64'h6361, 64'd0, 64'h51, 64'd0, 4'b0101);
        queue_item("c", 1'b1);
        wait_idle();

        // longest replacement with line end, then deletion
        apply_settings(64'h63, 64'd1, 64'h3837363534333231, 64'd8, 4'hF);
        queue_item("c", 1'b1);
        wait_idle();
        apply_settings(64'h0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFF0, 4'b1000);
        queue_item("c", 1'b0);
        queue_item("c", 1'b1);
        wait_idle();

        // oversized lengths, full window miss and flush
        apply_settings('1, 64'hDEAD_0000_0000_000F, 64'h0807060504030201, 64'd12, 4'hF);
        repeat (7) queue_item(8'hFF, 1'b0);
        queue_item(8'hFE, 1'b1);
        wait_idle();

        // random phases until the whole run reaches its item count
        phase_no = 0;
        while (items_queued < RANDOM_ITEMS)
        begin
            random_settings(phase_no == 0);
            hold_phase = (phase_no == 2) || ($urandom_range(0, 19) == 0);
            idling_on = hold_phase ? 1'b0 : ($urandom_range(0, 4) != 0);
            if (hold_phase)
                hold_req++;
            count = $urandom_range(10, 50);
            queue_phase(count, $urandom_range(0, 2) == 0);
            wait_idle();
            phase_no++;
        end

        idling_on = 1'b0;
        wait_idle();
        repeat (10) @(posedge clk);
        if (replaced_stream.size() != 0)
        begin
            errors++;
            $display("%0t: %0d predicted items never came out", $time, replaced_stream.size());
        end
        $display("Ran %0d text bytes in %0d lines under %0d register settings (%0d writes)",
                 items_accepted, lines_queued, settings_used, cfg_writes);
        $display("Compared %0d output items, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("tb_stream_find_replace passed");
        else
            $display("tb_stream_find_replace failed");
        $finish;
    end

endmodule
